### hdl/pdtp_pkg.sv
// ----------------------------------------------------------------------------
// pdtp_pkg
// Types and constants shared by the PWM duty and ADC trigger placer.
// ----------------------------------------------------------------------------
package pdtp_pkg;

    // Register map indexes (byte address = 4 * index)
    localparam logic [2:0] REG_PERIOD = 3'd0;
    localparam logic [2:0] REG_MAX    = 3'd1;
    localparam logic [2:0] REG_MIN    = 3'd2;
    localparam logic [2:0] REG_SCAN   = 3'd3;
    localparam logic [2:0] REG_GUARD  = 3'd4;

    localparam int ADDR_W = 5;

    // Reset values of the registers
    localparam logic [15:0] PERIOD_RST = 16'd27200;
    localparam logic [15:0] MAX_RST    = 16'd55706;
    localparam logic [15:0] MIN_RST    = 16'd3277;
    localparam logic [15:0] SCAN_RST   = 16'd7107;
    localparam logic [14:0] GUARD_RST  = 15'd1000;

    // Window placement outcomes
    localparam logic [2:0] WC_OFF_GUARD = 3'd0;
    localparam logic [2:0] WC_ON_GUARD  = 3'd1;
    localparam logic [2:0] WC_OFF_BARE  = 3'd2;
    localparam logic [2:0] WC_ON_BARE   = 3'd3;
    localparam logic [2:0] WC_EDGE      = 3'd4;

    typedef struct packed {
        logic [15:0] period_ticks;
        logic [15:0] duty_ceil;
        logic [15:0] duty_floor;
        logic [15:0] scan_ticks;
        logic [14:0] guard_ticks;
    } cfg_t;

    // Clamped duty and switch-off compare, passed to the placement stage
    typedef struct packed {
        logic [15:0] duty;
        logic [15:0] cmp;
    } mid_t;

    typedef struct packed {
        logic [15:0] applied_duty;
        logic [15:0] edge_compare;
        logic [15:0] adc_trigger_compare;
        logic [2:0]  window_case;
    } res_t;

endpackage

### hdl/pdtp_if.sv
// ----------------------------------------------------------------------------
// pdtp_req_if / pdtp_res_if
// Valid/ready channels carrying duty requests and placement results.
// ----------------------------------------------------------------------------
interface pdtp_req_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] duty_request;

    modport source (output valid, output duty_request, input ready);
    modport sink   (input valid, input duty_request, output ready);
endinterface

interface pdtp_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] applied_duty;
    logic [15:0] edge_compare;
    logic [15:0] adc_trigger_compare;
    logic [2:0]  window_case;

    modport source (output valid, output applied_duty, output edge_compare,
                    output adc_trigger_compare, output window_case, input ready);
    modport sink   (input valid, input applied_duty, input edge_compare,
                    input adc_trigger_compare, input window_case, output ready);
endinterface

### hdl/pwm_duty_and_adc_trigger_placer.sv
// ----------------------------------------------------------------------------
// pwm_duty_and_adc_trigger_placer
// Duty clamp, switch-off compare and ADC trigger placement.
// ----------------------------------------------------------------------------
// Takes one duty request per clock unless both stages hold a request and
// the output stalls; one result per request returns in order. The
// first stage clamps the request and does the 16x16 period multiply; the
// second stage places the trigger window and saturates it, feeding the
// output register. A new request is taken while a finished result waits,
// as long as the multiply stage is free. Registers are written over APB at
// byte address 4*index and should only change while no request is in flight.
// ----------------------------------------------------------------------------
module pwm_duty_and_adc_trigger_placer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdtp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    pdtp_req_if.sink                    req,
    pdtp_res_if.source                  res
);
    import pdtp_pkg::*;

    cfg_t cfg;
    mid_t mid_comb;
    mid_t mid_reg;
    res_t res_comb;
    res_t res_reg;
    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic adv2;
    logic take;

    pdtp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdtp_clamp_mul u_clamp_mul (
        .duty_request (req.duty_request),
        .cfg          (cfg),
        .mid          (mid_comb)
    );

    pdtp_place u_place (
        .mid (mid_reg),
        .cfg (cfg),
        .res (res_comb)
    );

    // Advance when the next stage is empty or draining
    assign adv2      = !v2_reg || res.ready;
    assign req.ready = !v1_reg || adv2;
    assign take      = req.valid && req.ready;
    assign v1_next   = req.ready ? req.valid : v1_reg;
    assign v2_next   = adv2 ? v1_reg : v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Load payload stages
    always_ff @(posedge clk)
    begin
        if (take)
            mid_reg <= mid_comb;
        if (adv2 && v1_reg)
            res_reg <= res_comb;
    end

    assign res.valid               = v2_reg;
    assign res.applied_duty        = res_reg.applied_duty;
    assign res.edge_compare        = res_reg.edge_compare;
    assign res.adc_trigger_compare = res_reg.adc_trigger_compare;
    assign res.window_case         = res_reg.window_case;

`ifndef SYNTHESIS
    // Input stalls only when both stages hold a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (v1_reg && v2_reg))
        else $error("request stalled with a free stage");

    // A stalled stage-one request moves on once the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && res.ready) |=> v2_reg)
        else $error("stage-one request lost");

    // Trigger stays inside the period
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && cfg.period_ticks != 16'd0)
            |-> (res.adc_trigger_compare < cfg.period_ticks))
        else $error("trigger beyond period");

    // Switch-off compare never exceeds the period
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.edge_compare <= cfg.period_ticks))
        else $error("edge compare beyond period");
`endif

endmodule

### hdl/pdtp_regs.sv
// ----------------------------------------------------------------------------
// pdtp_regs
// APB register file holding period, duty limits, scan length and guard band.
// ----------------------------------------------------------------------------
module pdtp_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pdtp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output pdtp_pkg::cfg_t            cfg
);
    import pdtp_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [2:0]  idx;
    logic        wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Decode a write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_PERIOD: cfg_next.period_ticks = pwdata[15:0];
                REG_MAX:    cfg_next.duty_ceil    = pwdata[15:0];
                REG_MIN:    cfg_next.duty_floor   = pwdata[15:0];
                REG_SCAN:   cfg_next.scan_ticks   = pwdata[15:0];
                REG_GUARD:  cfg_next.guard_ticks  = pwdata[14:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks <= PERIOD_RST;
            cfg_reg.duty_ceil    <= MAX_RST;
            cfg_reg.duty_floor   <= MIN_RST;
            cfg_reg.scan_ticks   <= SCAN_RST;
            cfg_reg.guard_ticks  <= GUARD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (idx)
            REG_PERIOD: prdata = {16'd0, cfg_reg.period_ticks};
            REG_MAX:    prdata = {16'd0, cfg_reg.duty_ceil};
            REG_MIN:    prdata = {16'd0, cfg_reg.duty_floor};
            REG_SCAN:   prdata = {16'd0, cfg_reg.scan_ticks};
            REG_GUARD:  prdata = {17'd0, cfg_reg.guard_ticks};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

### hdl/pdtp_clamp_mul.sv
// ----------------------------------------------------------------------------
// pdtp_clamp_mul
// Clamp the requested duty to the limits and scale it by the period.
// ----------------------------------------------------------------------------
module pdtp_clamp_mul (
    input  logic signed [17:0] duty_request,
    input  pdtp_pkg::cfg_t     cfg,
    output pdtp_pkg::mid_t     mid
);
    import pdtp_pkg::*;

    logic signed [17:0] max_s;
    logic signed [17:0] min_s;
    logic [15:0]        duty;
    logic [31:0]        prod;

    assign max_s = $signed({2'b00, cfg.duty_ceil});
    assign min_s = $signed({2'b00, cfg.duty_floor});

    // Upper limit wins over lower limit
    always_comb
    begin
        if (duty_request > max_s)
            duty = cfg.duty_ceil;
        else if (duty_request < min_s)
            duty = cfg.duty_floor;
        else
            duty = duty_request[15:0];
    end

    // Switch-off tick = floor(period * duty / 2^16)
    assign prod     = 32'(cfg.period_ticks) * 32'(duty);
    assign mid.duty = duty;
    assign mid.cmp  = prod[31:16];

endmodule

### hdl/pdtp_place.sv
// ----------------------------------------------------------------------------
// pdtp_place
// Place the ADC trigger in the off or on interval of the PWM period.
// ----------------------------------------------------------------------------
module pdtp_place (
    input  pdtp_pkg::mid_t mid,
    input  pdtp_pkg::cfg_t cfg,
    output pdtp_pkg::res_t res
);
    import pdtp_pkg::*;

    logic [16:0] on_t;
    logic [16:0] off_t;
    logic [16:0] need;
    logic [16:0] scan;
    logic [16:0] span;
    logic [17:0] base;
    logic [17:0] trig;
    logic [17:0] period;
    logic [2:0]  wcase;

    assign on_t   = {1'b0, mid.cmp};
    assign off_t  = {1'b0, cfg.period_ticks - mid.cmp};
    assign scan   = {1'b0, cfg.scan_ticks};
    assign need   = scan + {1'b0, cfg.guard_ticks, 1'b0};
    assign period = {2'b00, cfg.period_ticks};

    // Pick the interval and the slack to split
    always_comb
    begin
        if (off_t >= need && (off_t >= on_t || on_t < need))
        begin
            wcase = WC_OFF_GUARD;
            base  = {2'b00, mid.cmp} + {3'b000, cfg.guard_ticks};
            span  = off_t - need;
        end
        else if (on_t >= need)
        begin
            wcase = WC_ON_GUARD;
            base  = {3'b000, cfg.guard_ticks};
            span  = on_t - need;
        end
        else if (off_t >= scan)
        begin
            wcase = WC_OFF_BARE;
            base  = {2'b00, mid.cmp};
            span  = off_t - scan;
        end
        else if (on_t >= scan)
        begin
            wcase = WC_ON_BARE;
            base  = 18'd0;
            span  = on_t - scan;
        end
        else
        begin
            wcase = WC_EDGE;
            base  = {2'b00, mid.cmp};
            span  = 17'd0;
        end
    end

    assign trig = base + {2'b00, span[16:1]};

    // Saturate to the last tick of the period
    always_comb
    begin
        res.applied_duty = mid.duty;
        res.edge_compare = mid.cmp;
        res.window_case  = wcase;
        if (cfg.period_ticks == 16'd0)
            res.adc_trigger_compare = 16'd0;
        else if (trig >= period)
            res.adc_trigger_compare = cfg.period_ticks - 16'd1;
        else
            res.adc_trigger_compare = trig[15:0];
    end

endmodule

### bench/pwm_duty_and_adc_trigger_placer_tb.sv
// ----------------------------------------------------------------------------
// pwm_duty_and_adc_trigger_placer_tb
// Self-checking bench for the PWM duty clamp and ADC trigger placer.
// ----------------------------------------------------------------------------
// Duty requests go in through a clocked driver fed from a backlog queue. Each
// accepted request is run through a local placement predictor, and a clocked
// monitor checks every result against the oldest prediction, field by field.
// The run walks through several register settings (reset values, extremes,
// swapped limits, zero period, oversized windows and random ones). It also
// varies the idle rates on both channels.
// ----------------------------------------------------------------------------
module pwm_duty_and_adc_trigger_placer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdtp_pkg::*;

    localparam int PHASES          = 12;
    localparam int REQS_PER_PHASE  = 138;
    localparam int PAUSE_PHASE     = 5;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 200000;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    pdtp_req_if req_ch ();
    pdtp_res_if res_ch ();

    // Register mirror, request backlog and predicted placements
    cfg_t                cfg_shadow;
    logic signed [17:0]  duty_backlog[$];
    res_t                placements_due[$];
    logic signed [17:0]  duty_on_bus;

    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    pwm_duty_and_adc_trigger_placer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Clamp the duty, compute the switch-off tick and place the ADC window
    function automatic res_t place_window(input logic signed [17:0] request);
        int          req_val;
        logic [15:0] duty;
        logic [31:0] period;
        logic [31:0] cmp;
        logic [31:0] span_on;
        logic [31:0] span_off;
        logic [31:0] scan;
        logic [31:0] guard;
        logic [31:0] need;
        logic [31:0] trig;
        logic [2:0]  wcase;
        res_t        r;
        req_val = request;
        period  = 32'(cfg_shadow.period_ticks);
        scan    = 32'(cfg_shadow.scan_ticks);
        guard   = 32'(cfg_shadow.guard_ticks);
        if (req_val > int'(cfg_shadow.duty_ceil))
            duty = cfg_shadow.duty_ceil;
        else if (req_val < int'(cfg_shadow.duty_floor))
            duty = cfg_shadow.duty_floor;
        else
            duty = req_val[15:0];
        cmp      = (period * 32'(duty)) >> 16;
        span_on  = cmp;
        span_off = period - cmp;
        need     = scan + 2 * guard;
        if (span_off >= need && (span_off >= span_on || span_on < need))
        begin
            trig  = cmp + guard + (span_off - need) / 2;
            wcase = WC_OFF_GUARD;
        end
        else if (span_on >= need)
        begin
            trig  = guard + (span_on - need) / 2;
            wcase = WC_ON_GUARD;
        end
        else if (span_off >= scan)
        begin
            trig  = cmp + (span_off - scan) / 2;
            wcase = WC_OFF_BARE;
        end
        else if (span_on >= scan)
        begin
            trig  = (span_on - scan) / 2;
            wcase = WC_ON_BARE;
        end
        else
        begin
            trig  = cmp;
            wcase = WC_EDGE;
        end
        // Saturate the trigger inside the period
        if (period == 0)
            trig = 0;
        else if (trig >= period)
            trig = period - 1;
        r.applied_duty        = duty;
        r.edge_compare        = cmp[15:0];
        r.adc_trigger_compare = trig[15:0];
        r.window_case         = wcase;
        return r;
    endfunction

    // Pick a request: raw 18-bit noise, limit boundaries, or the legal band
    function automatic logic signed [17:0] pick_request();
        int lo;
        int hi;
        int v;
        lo = int'(cfg_shadow.duty_floor);
        hi = int'(cfg_shadow.duty_ceil);
        if (lo > hi)
        begin
            v  = lo;
            lo = hi;
            hi = v;
        end
        case ($urandom_range(9))
            0, 1, 2: v = int'($urandom_range(0, 262143)) - 131072;
            3:
            begin
                case ($urandom_range(9))
                    0: v = hi - 1;
                    1: v = hi;
                    2: v = hi + 1;
                    3: v = lo - 1;
                    4: v = lo;
                    5: v = lo + 1;
                    6: v = 0;
                    7: v = -1;
                    8: v = 65535;
                    default: v = 65536;
                endcase
            end
            default: v = int'($urandom_range(lo, hi));
        endcase
        return 18'(v);
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.period_ticks = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 200))
                                                  : 16'($urandom());
        c.duty_ceil    = 16'($urandom_range(16384, 65535));
        c.duty_floor   = 16'($urandom_range(0, 16384));
        if ($urandom_range(4) == 0)
        begin
            c.duty_ceil  = 16'($urandom_range(0, 16384));
            c.duty_floor = 16'($urandom_range(16384, 65535));
        end
        c.scan_ticks   = 16'($urandom_range(0, c.period_ticks / 2));
        c.guard_ticks  = 15'($urandom_range(0, c.period_ticks / 4));
        return c;
    endfunction

    function automatic cfg_t setting_for(input int phase);
        case (phase)
            1:       return '{16'd65535, 16'd65535, 16'd0, 16'd0, 15'd0};
            2:       return '{16'd0, 16'd65535, 16'd0, 16'd7107, 15'd1000};
            3:       return '{16'd1, 16'd65535, 16'd0, 16'd0, 15'd0};
            4:       return '{16'd27200, 16'd1000, 16'd50000, 16'd7107, 15'd1000};
            5:       return '{16'd65535, 16'd65535, 16'd0, 16'd65535, 15'd32767};
            6:       return '{16'd10000, 16'd65535, 16'd0, 16'd4000, 15'd2000};
            7:       return '{16'd10000, 16'd65535, 16'd0, 16'd6000, 15'd1000};
            8:       return '{16'd100, 16'd65535, 16'd0, 16'd30, 15'd10};
            default: return random_setting();
        endcase
    endfunction

    // APB write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PERIOD: cfg_shadow.period_ticks = value[15:0];
            REG_MAX:    cfg_shadow.duty_ceil    = value[15:0];
            REG_MIN:    cfg_shadow.duty_floor   = value[15:0];
            REG_SCAN:   cfg_shadow.scan_ticks   = value[15:0];
            REG_GUARD:  cfg_shadow.guard_ticks  = value[14:0];
            default:    ;
        endcase
    endtask

    task automatic apply_setting(input cfg_t c);
        reg_write(REG_PERIOD, 32'(c.period_ticks));
        reg_write(REG_MAX, 32'(c.duty_ceil));
        reg_write(REG_MIN, 32'(c.duty_floor));
        reg_write(REG_SCAN, 32'(c.scan_ticks));
        reg_write(REG_GUARD, 32'(c.guard_ticks));
    endtask

    // Hold until every request is sent and every placement has come back
    task automatic wait_for_drain();
        while (duty_backlog.size() != 0 || req_ch.valid || placements_due.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: advance on acceptance, idle at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                placements_due.push_back(place_window(duty_on_bus));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (duty_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    duty_on_bus = duty_backlog.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.duty_request <= duty_on_bus;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall at random, check against the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            if (res_ch.valid && res_ch.ready)
            begin
                if (placements_due.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (res_ch.applied_duty !== want.applied_duty)
                    begin
                        $error("applied_duty: expected %0d, got %0d",
                               want.applied_duty, res_ch.applied_duty);
                        mismatch_count++;
                    end
                    if (res_ch.edge_compare !== want.edge_compare)
                    begin
                        $error("edge_compare: expected %0d, got %0d",
                               want.edge_compare, res_ch.edge_compare);
                        mismatch_count++;
                    end
                    if (res_ch.adc_trigger_compare !== want.adc_trigger_compare)
                    begin
                        $error("adc_trigger_compare: expected %0d, got %0d",
                               want.adc_trigger_compare, res_ch.adc_trigger_compare);
                        mismatch_count++;
                    end
                    if (res_ch.window_case !== want.window_case)
                    begin
                        $error("window_case: expected %0d, got %0d",
                               want.window_case, res_ch.window_case);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic signed [17:0] directed[$];
        int                 n;
        req_ch.valid        = 1'b0;
        req_ch.duty_request = '0;
        res_ch.ready        = 1'b0;
        cfg_shadow = '{PERIOD_RST, MAX_RST, MIN_RST, SCAN_RST, GUARD_RST};
        directed = '{18'sd0, 18'sd1, -18'sd1, 18'sh20000, 18'sd131071,
                     18'sd65535, 18'sd65536, 18'(int'(MAX_RST)),
                     18'(int'(MAX_RST) + 1), 18'(int'(MAX_RST) - 1),
                     18'(int'(MIN_RST)), 18'(int'(MIN_RST) - 1),
                     18'(int'(MIN_RST) + 1), 18'sd16384, 18'sd32768,
                     18'sd49152, 18'sd22000, 18'sd43000, -18'sd3277, 18'sd100};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
                apply_setting(setting_for(phase));
            // Idle mix: receiver-heavy, then sender-heavy, then none
            if (phase < 4)
            begin
                src_idle_pct  = 30;
                sink_idle_pct = 61;
            end
            else if (phase < 8)
            begin
                src_idle_pct  = 61;
                sink_idle_pct = 30;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            n = REQS_PER_PHASE;
            if (phase == 0)
            begin
                foreach (directed[i])
                    duty_backlog.push_back(directed[i]);
                n -= directed.size();
            end
            for (int i = 0; i < n; i++)
            begin
                // Stop sending mid-phase until the pipeline is empty
                if (phase == PAUSE_PHASE && i == n / 2)
                    wait_for_drain();
                duty_backlog.push_back(pick_request());
            end
            wait_for_drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && placements_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
